// ===== rtl/complex_arithmetic_unit_defines.svh =====
// assertion macros for the complex arithmetic unit checker
// expects clk and rst_n in the scope where a macro is used
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CAU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex arithmetic unit check failed");

// next-cycle implication, disabled in reset
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex arithmetic unit check failed");

`endif

// ===== rtl/cau_pkg.sv =====
// shared types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_BITS  = 17;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 17'd1;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_CDIV    = 4'd3,
        OP_SCALE   = 4'd4,
        OP_RDIV    = 4'd5,
        OP_CONJ    = 4'd6,
        OP_MODULUS = 4'd7,
        OP_EQUAL   = 4'd8
    } op_t;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // control that travels with an item down the pipeline
    typedef struct packed {
        logic use_div;
        logic use_sqrt;
        logic dz;
        logic eq;
        logic clamped;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } ctrl_t;

endpackage

// ===== rtl/cau_front.sv =====
// front end: operand register with products, then sums and direct results
// depends on cau_pkg
module cau_front #(
    parameter int W = cau_pkg::WORD_BITS,
    parameter int F = cau_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [3:0]                    in_op,
    input  logic signed [W-1:0]           ar,
    input  logic signed [W-1:0]           ai,
    input  logic signed [W-1:0]           br,
    input  logic signed [W-1:0]           bi,
    input  logic [cau_pkg::TOL_BITS-1:0]  tol,
    output logic                          out_valid,
    output cau_pkg::ctrl_t                out_ctrl,
    output logic [W-1:0]                  out_re,
    output logic [W-1:0]                  out_im,
    output logic signed [2*W:0]           out_n_re,
    output logic signed [2*W:0]           out_n_im,
    output logic signed [2*W:0]           out_den,
    output logic [2*W-1:0]                out_sq
);
    localparam int PW = 2 * W;
    localparam int XW = PW + 1;
    localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] MINV = ~MAXV;

    // clamp to the word range, flag in the top bit
    function automatic logic [W:0] sat_x(input logic signed [XW-1:0] x);
        if (x > MAXV)
            sat_x = {1'b1, MAXV[W-1:0]};
        else if (x < MINV)
            sat_x = {1'b1, MINV[W-1:0]};
        else
            sat_x = {1'b0, x[W-1:0]};
    endfunction

    logic                v1_reg;
    logic [3:0]          op1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [PW-1:0] pbb_reg, pb2_reg, paa_reg, pa2_reg;

    // stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    // stage 1 operands and products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg <= in_op;
            ar1_reg <= ar;
            ai1_reg <= ai;
            br1_reg <= br;
            bi1_reg <= bi;
            prr_reg <= ar * br;
            pii_reg <= ai * bi;
            pri_reg <= ar * bi;
            pir_reg <= ai * br;
            pbb_reg <= br * br;
            pb2_reg <= bi * bi;
            paa_reg <= ar * ar;
            pa2_reg <= ai * ai;
        end
    end

    logic signed [XW-1:0] s_re, s_im, n_re_next, n_im_next, den_next;
    logic [W:0]           sat_re, sat_im;
    logic signed [W:0]    d_r, d_i;
    logic [W:0]           abs_r, abs_i;
    cau_pkg::ctrl_t       ctrl_next;

    // stage 2 sums, direct results and divider operands
    always_comb
    begin
        d_r   = (W+1)'(ar1_reg) - (W+1)'(br1_reg);
        d_i   = (W+1)'(ai1_reg) - (W+1)'(bi1_reg);
        abs_r = d_r[W] ? (W+1)'(-d_r) : (W+1)'(d_r);
        abs_i = d_i[W] ? (W+1)'(-d_i) : (W+1)'(d_i);
        s_re      = '0;
        s_im      = '0;
        n_re_next = '0;
        n_im_next = '0;
        den_next  = '0;
        ctrl_next = '0;
        case (op1_reg)
            cau_pkg::OP_ADD:
            begin
                s_re = XW'(ar1_reg) + XW'(br1_reg);
                s_im = XW'(ai1_reg) + XW'(bi1_reg);
            end
            cau_pkg::OP_SUB:
            begin
                s_re = XW'(ar1_reg) - XW'(br1_reg);
                s_im = XW'(ai1_reg) - XW'(bi1_reg);
            end
            cau_pkg::OP_MUL:
            begin
                s_re = (XW'(prr_reg) - XW'(pii_reg)) >>> F;
                s_im = (XW'(pri_reg) + XW'(pir_reg)) >>> F;
            end
            cau_pkg::OP_CDIV:
            begin
                n_re_next = XW'(prr_reg) + XW'(pii_reg);
                n_im_next = XW'(pir_reg) - XW'(pri_reg);
                den_next  = XW'(pbb_reg) + XW'(pb2_reg);
                ctrl_next.use_div = 1'b1;
                ctrl_next.dz = (br1_reg == '0) && (bi1_reg == '0);
            end
            cau_pkg::OP_SCALE:
            begin
                s_re = XW'(prr_reg) >>> F;
                s_im = XW'(pir_reg) >>> F;
            end
            cau_pkg::OP_RDIV:
            begin
                n_re_next = XW'(ar1_reg);
                n_im_next = XW'(ai1_reg);
                den_next  = XW'(br1_reg);
                ctrl_next.use_div = 1'b1;
                ctrl_next.dz = (br1_reg == '0);
            end
            cau_pkg::OP_CONJ:
            begin
                s_re = XW'(ar1_reg);
                s_im = -XW'(ai1_reg);
            end
            cau_pkg::OP_MODULUS:
                ctrl_next.use_sqrt = 1'b1;
            cau_pkg::OP_EQUAL:
                ctrl_next.eq = (abs_r < (W+1)'(tol)) && (abs_i < (W+1)'(tol));
            default:
                ctrl_next = '0;
        endcase
        sat_re = sat_x(s_re);
        sat_im = sat_x(s_im);
        ctrl_next.clamped = sat_re[W] | sat_im[W];
    end

    // stage 2 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= v1_reg;
    end

    // stage 2 payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ctrl <= ctrl_next;
            out_re   <= sat_re[W-1:0];
            out_im   <= sat_im[W-1:0];
            out_n_re <= n_re_next;
            out_n_im <= n_im_next;
            out_den  <= den_next;
            out_sq   <= PW'($unsigned(paa_reg)) + PW'($unsigned(pa2_reg));
        end
    end

endmodule

// ===== rtl/cau_div_prep.sv =====
// divider setup: magnitudes and signs, then quotient overflow check
// depends on cau_pkg
module cau_div_prep #(
    parameter int W = cau_pkg::WORD_BITS,
    parameter int F = cau_pkg::FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  cau_pkg::ctrl_t         in_ctrl,
    input  logic [W-1:0]           in_re,
    input  logic [W-1:0]           in_im,
    input  logic signed [2*W:0]    n_re,
    input  logic signed [2*W:0]    n_im,
    input  logic signed [2*W:0]    den,
    input  logic [2*W-1:0]         in_sq,
    output logic                   out_valid,
    output cau_pkg::ctrl_t         out_ctrl,
    output logic [W-1:0]           out_re,
    output logic [W-1:0]           out_im,
    output logic [3*W+F-1:0]       rem_re,
    output logic [3*W+F-1:0]       rem_im,
    output logic [3*W+F-1:0]       dmag,
    output logic [2*W-1:0]         out_sq
);
    localparam int XW = 2 * W + 1;
    localparam int CW = 3 * W + F;

    logic            v3_reg;
    cau_pkg::ctrl_t  ctrl3_reg;
    logic [W-1:0]    re3_reg, im3_reg;
    logic [2*W-1:0]  sq3_reg;
    logic [CW-1:0]   nre3_reg, nim3_reg, d3_reg;
    logic [XW-1:0]   mag_re, mag_im, mag_d;
    cau_pkg::ctrl_t  ctrl3_next, ctrl4_next;

    // stage 3 magnitudes
    always_comb
    begin
        mag_re = n_re[XW-1] ? XW'(-n_re) : XW'(n_re);
        mag_im = n_im[XW-1] ? XW'(-n_im) : XW'(n_im);
        mag_d  = den[XW-1] ? XW'(-den) : XW'(den);
        ctrl3_next = in_ctrl;
        ctrl3_next.neg_re = n_re[XW-1] ^ den[XW-1];
        ctrl3_next.neg_im = n_im[XW-1] ^ den[XW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg    <= in_valid;
            out_valid <= v3_reg;
        end
    end

    // stage 4 overflow when the quotient needs more than the word
    always_comb
    begin
        ctrl4_next = ctrl3_reg;
        ctrl4_next.ovf_re = nre3_reg >= (d3_reg << W);
        ctrl4_next.ovf_im = nim3_reg >= (d3_reg << W);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl3_reg <= ctrl3_next;
            re3_reg   <= in_re;
            im3_reg   <= in_im;
            sq3_reg   <= in_sq;
            nre3_reg  <= CW'(mag_re) << F;
            nim3_reg  <= CW'(mag_im) << F;
            d3_reg    <= CW'(mag_d);
            out_ctrl  <= ctrl4_next;
            out_re    <= re3_reg;
            out_im    <= im3_reg;
            out_sq    <= sq3_reg;
            rem_re    <= nre3_reg;
            rem_im    <= nim3_reg;
            dmag      <= d3_reg;
        end
    end

endmodule

// ===== rtl/cau_div_step.sv =====
// one stage of the restoring dividers and the square root, one bit each
// depends on cau_pkg
module cau_div_step #(
    parameter int W    = cau_pkg::WORD_BITS,
    parameter int F    = cau_pkg::FRAC_BITS,
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  cau_pkg::ctrl_t      in_ctrl,
    input  logic [W-1:0]        in_re,
    input  logic [W-1:0]        in_im,
    input  logic [3*W+F-1:0]    in_rem_re,
    input  logic [3*W+F-1:0]    in_rem_im,
    input  logic [3*W+F-1:0]    in_dmag,
    input  logic [W-1:0]        in_q_re,
    input  logic [W-1:0]        in_q_im,
    input  logic [2*W:0]        in_sq_rem,
    input  logic [W-1:0]        in_sq_res,
    output logic                out_valid,
    output cau_pkg::ctrl_t      out_ctrl,
    output logic [W-1:0]        out_re,
    output logic [W-1:0]        out_im,
    output logic [3*W+F-1:0]    out_rem_re,
    output logic [3*W+F-1:0]    out_rem_im,
    output logic [3*W+F-1:0]    out_dmag,
    output logic [W-1:0]        out_q_re,
    output logic [W-1:0]        out_q_im,
    output logic [2*W:0]        out_sq_rem,
    output logic [W-1:0]        out_sq_res
);
    localparam int CW = 3 * W + F;
    localparam int SW = 2 * W + 1;

    logic [CW-1:0] t_div;
    logic [SW-1:0] t_sq;
    logic          ge_re, ge_im, ge_sq;
    logic [W-1:0]  q_re_next, q_im_next, res_next;

    // trial subtract for this quotient bit and root bit
    always_comb
    begin
        t_div = in_dmag << STEP;
        t_sq  = (SW'(in_sq_res) << (STEP + 1)) + (SW'(1) << (2 * STEP));
        ge_re = in_rem_re >= t_div;
        ge_im = in_rem_im >= t_div;
        ge_sq = in_sq_rem >= t_sq;
        q_re_next = in_q_re;
        q_im_next = in_q_im;
        res_next  = in_sq_res;
        q_re_next[STEP] = ge_re;
        q_im_next[STEP] = ge_im;
        res_next[STEP]  = ge_sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_ctrl   <= in_ctrl;
            out_re     <= in_re;
            out_im     <= in_im;
            out_dmag   <= in_dmag;
            out_rem_re <= ge_re ? in_rem_re - t_div : in_rem_re;
            out_rem_im <= ge_im ? in_rem_im - t_div : in_rem_im;
            out_q_re   <= q_re_next;
            out_q_im   <= q_im_next;
            out_sq_rem <= ge_sq ? in_sq_rem - t_sq : in_sq_rem;
            out_sq_res <= res_next;
        end
    end

endmodule

// ===== rtl/cau_back.sv =====
// result select, quotient and root saturation, output register
// depends on cau_pkg
module cau_back #(
    parameter int W = cau_pkg::WORD_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  cau_pkg::ctrl_t  in_ctrl,
    input  logic [W-1:0]    in_re,
    input  logic [W-1:0]    in_im,
    input  logic [W-1:0]    q_re,
    input  logic [W-1:0]    q_im,
    input  logic [W-1:0]    sq_res,
    output logic            out_valid,
    output logic [W-1:0]    res_re,
    output logic [W-1:0]    res_im,
    output logic            are_equal,
    output logic [1:0]      status
);
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    // signed quotient from magnitude, clamp flag on top
    function automatic logic [W:0] div_sat(input logic neg, input logic ovf,
                                           input logic [W-1:0] q);
        if (!neg)
            div_sat = (ovf || q[W-1]) ? {1'b1, MAXW} : {1'b0, q};
        else
            div_sat = (ovf || q > MINW) ? {1'b1, MINW} : {1'b0, W'(-q)};
    endfunction

    logic [W:0]   d_re, d_im;
    logic [W-1:0] re_next, im_next;
    logic         clamp_next;
    logic [1:0]   status_next;

    // pick the result source
    always_comb
    begin
        d_re = div_sat(in_ctrl.neg_re, in_ctrl.ovf_re, q_re);
        d_im = div_sat(in_ctrl.neg_im, in_ctrl.ovf_im, q_im);
        re_next    = in_re;
        im_next    = in_im;
        clamp_next = in_ctrl.clamped;
        if (in_ctrl.dz)
        begin
            re_next    = '0;
            im_next    = '0;
            clamp_next = 1'b0;
        end
        else if (in_ctrl.use_div)
        begin
            re_next    = d_re[W-1:0];
            im_next    = d_im[W-1:0];
            clamp_next = d_re[W] | d_im[W];
        end
        else if (in_ctrl.use_sqrt)
        begin
            re_next    = sq_res[W-1] ? MAXW : sq_res;
            im_next    = '0;
            clamp_next = sq_res[W-1];
        end
        if (in_ctrl.dz)
            status_next = cau_pkg::ST_DZ;
        else if (clamp_next)
            status_next = cau_pkg::ST_SAT;
        else
            status_next = cau_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re    <= re_next;
            res_im    <= im_next;
            are_equal <= in_ctrl.eq;
            status    <= status_next;
        end
    end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// top level of the complex arithmetic unit: stream ports and pipeline chain
// depends on cau_pkg, cau_front, cau_div_prep, cau_div_step, cau_back
//
// Pipelined complex ALU in signed fixed point (Q16.16 by default). One beat
// in gives one beat out, in order, and a new beat is taken every cycle while
// the output side keeps up. The pipeline has two front stages for products
// and sums, two divider setup stages, one stage per quotient and root bit
// (the dividers and square root share these WORD_BITS stages), and the
// output register. The whole pipeline holds while a result waits, so
// s_tready is low only when m_tvalid is high and m_tready low. The tolerance
// register may be written while the pipeline is empty.
module complex_arithmetic_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cau_pkg::TOL_BITS-1:0]         cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // a_real, a_imag, b_real, b_imag, zero pad
    input  logic [((4*WORD_BITS+7)/8)*8-1:0]     s_tdata,
    // opcode
    input  logic [3:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // res_real, res_imag, zero pad
    output logic [((2*WORD_BITS+7)/8)*8-1:0]     m_tdata,
    // are_equal, status
    output logic [2:0]                           m_tuser
);
    localparam int W  = WORD_BITS;
    localparam int CW = 3 * W + FRAC_BITS;
    localparam int OUT_TDW = ((2*W+7)/8)*8;

    logic [cau_pkg::TOL_BITS-1:0] tol_reg;
    logic adv;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= cau_pkg::TOL_RESET;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    // whole pipeline moves when the output register is free
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic               v2;
    cau_pkg::ctrl_t     ctrl2;
    logic [W-1:0]       re2, im2;
    logic signed [2*W:0] nre2, nim2, den2;
    logic [2*W-1:0]     sq2, sq4;

    cau_front #(.W(W), .F(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(s_tvalid),
        .in_op(s_tuser),
        .ar(s_tdata[W-1:0]), .ai(s_tdata[2*W-1:W]),
        .br(s_tdata[3*W-1:2*W]), .bi(s_tdata[4*W-1:3*W]),
        .tol(tol_reg),
        .out_valid(v2), .out_ctrl(ctrl2), .out_re(re2), .out_im(im2),
        .out_n_re(nre2), .out_n_im(nim2), .out_den(den2), .out_sq(sq2)
    );

    logic            v_c [0:W];
    cau_pkg::ctrl_t  ctrl_c [0:W];
    logic [W-1:0]    re_c [0:W];
    logic [W-1:0]    im_c [0:W];
    logic [CW-1:0]   rre_c [0:W];
    logic [CW-1:0]   rim_c [0:W];
    logic [CW-1:0]   dm_c [0:W];
    logic [W-1:0]    qre_c [0:W];
    logic [W-1:0]    qim_c [0:W];
    logic [2*W:0]    srem_c [0:W];
    logic [W-1:0]    sres_c [0:W];

    cau_div_prep #(.W(W), .F(FRAC_BITS)) u_prep (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(v2), .in_ctrl(ctrl2), .in_re(re2), .in_im(im2),
        .n_re(nre2), .n_im(nim2), .den(den2), .in_sq(sq2),
        .out_valid(v_c[0]), .out_ctrl(ctrl_c[0]), .out_re(re_c[0]), .out_im(im_c[0]),
        .rem_re(rre_c[0]), .rem_im(rim_c[0]), .dmag(dm_c[0]), .out_sq(sq4)
    );

    // root and quotient start empty
    assign qre_c[0]  = '0;
    assign qim_c[0]  = '0;
    assign sres_c[0] = '0;
    assign srem_c[0] = (2*W+1)'(sq4);

    // one stage per bit, most significant first
    for (genvar k = 0; k < W; k++)
    begin : g_step
        cau_div_step #(.W(W), .F(FRAC_BITS), .STEP(W-1-k)) u_step (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_valid(v_c[k]), .in_ctrl(ctrl_c[k]), .in_re(re_c[k]), .in_im(im_c[k]),
            .in_rem_re(rre_c[k]), .in_rem_im(rim_c[k]), .in_dmag(dm_c[k]),
            .in_q_re(qre_c[k]), .in_q_im(qim_c[k]),
            .in_sq_rem(srem_c[k]), .in_sq_res(sres_c[k]),
            .out_valid(v_c[k+1]), .out_ctrl(ctrl_c[k+1]),
            .out_re(re_c[k+1]), .out_im(im_c[k+1]),
            .out_rem_re(rre_c[k+1]), .out_rem_im(rim_c[k+1]), .out_dmag(dm_c[k+1]),
            .out_q_re(qre_c[k+1]), .out_q_im(qim_c[k+1]),
            .out_sq_rem(srem_c[k+1]), .out_sq_res(sres_c[k+1])
        );
    end

    logic [W-1:0] res_re, res_im;
    logic         are_equal;
    logic [1:0]   status;

    cau_back #(.W(W)) u_back (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(v_c[W]), .in_ctrl(ctrl_c[W]), .in_re(re_c[W]), .in_im(im_c[W]),
        .q_re(qre_c[W]), .q_im(qim_c[W]), .sq_res(sres_c[W]),
        .out_valid(m_tvalid), .res_re(res_re), .res_im(res_im),
        .are_equal(are_equal), .status(status)
    );

    // output beat packing
    assign m_tdata = OUT_TDW'({res_im, res_re});
    assign m_tuser = {status, are_equal};

endmodule

// ===== rtl/cau_checker.sv =====
// port-level checks of the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit_defines.svh
`include "complex_arithmetic_unit_defines.svh"

module cau_checker #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((2*WORD_BITS+7)/8)*8-1:0]  m_tdata,
    input logic [2:0]                        m_tuser
);
    // input side takes a beat whenever the output register can move
    `CAU_ASSERT_SAME(a_ready_tracks_output, s_tvalid, s_tready == (!m_tvalid || m_tready))
    // a stalled result beat holds
    `CAU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // divide by zero gives a zero result and no equality
    `CAU_ASSERT_SAME(a_dz_zero, m_tvalid && (m_tuser[2:1] == cau_pkg::ST_DZ), (m_tdata == '0) && !m_tuser[0])
    // equality beats carry a zero value and ok status
    `CAU_ASSERT_SAME(a_eq_clean, m_tvalid && m_tuser[0], (m_tdata == '0) && (m_tuser[2:1] == cau_pkg::ST_OK))

endmodule

bind complex_arithmetic_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);

// ===== tb/tb_complex_arithmetic_unit.sv =====
// testbench for the complex arithmetic unit: random and directed complex operations
// depends on cau_pkg and complex_arithmetic_unit
module tb_complex_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = cau_pkg::WORD_BITS;
    localparam int F = cau_pkg::FRAC_BITS;
    localparam int LAT = W + 5;
    localparam int WATCHDOG = 20000;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        logic [3:0]          opcode;
        logic signed [W-1:0] ar, ai, br, bi;
    } op_item_t;

    typedef struct {
        logic signed [W-1:0] re, im;
        logic                eq;
        logic [1:0]          st;
    } cplx_result_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [cau_pkg::TOL_BITS-1:0] cfg_wr_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [4*W-1:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [2*W-1:0] m_tdata;
    logic [2:0] m_tuser;

    complex_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    op_item_t     pending_ops[$];
    cplx_result_t expected_results[$];
    logic [cau_pkg::TOL_BITS-1:0] tolerance = cau_pkg::TOL_RESET;
    logic [cau_pkg::TOL_BITS-1:0] tol_list [5] = '{17'd0, 17'd65536, 17'd7, 17'h1ffff, 17'd1};
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_req = 0;
    bit  hold_taken = 0;
    int  hold_left = 0;

    // clamp a wide value to the word range
    function automatic logic signed [W-1:0] clamp(input logic signed [2*W+F+2:0] x,
                                                    inout bit clamped);
        logic signed [2*W+F+2:0] hi;
        logic signed [2*W+F+2:0] lo;
        hi = (2*W+F+3)'({1'b0, {(W-1){1'b1}}});
        lo = -hi - 1;
        if (x > hi)
        begin
            clamped = 1;
            return hi[W-1:0];
        end
        if (x < lo)
        begin
            clamped = 1;
            return lo[W-1:0];
        end
        return x[W-1:0];
    endfunction

    // quotient truncated toward zero
    function automatic logic signed [2*W+F+2:0] quot(input logic signed [2*W+F+2:0] n,
                                                      input logic signed [2*W+F+2:0] d);
        logic [2*W+F+2:0] un, ud, q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = un / ud;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [W:0] root(input logic [2*W+1:0] n);
        logic [W:0] r, t;
        r = 0;
        for (int b = W; b >= 0; b--)
        begin
            t = r | ((W+1)'(1) << b);
            if ({{(W+1){1'b0}}, t} * {{(W+1){1'b0}}, t} <= {{W{1'b0}}, n}) r = t;
        end
        return r;
    endfunction

    // complex alu prediction
    function automatic cplx_result_t compute_result(input op_item_t it);
        cplx_result_t r;
        bit c;
        logic signed [2*W+F+2:0] ar, ai, br, bi, den, nr, ni;
        logic [2*W+1:0] mag2;
        logic [W:0] m;
        c = 0;
        r = '{re: 0, im: 0, eq: 0, st: cau_pkg::ST_OK};
        ar = it.ar; ai = it.ai; br = it.br; bi = it.bi;
        case (it.opcode)
            cau_pkg::OP_ADD:
            begin
                r.re = clamp(ar + br, c);
                r.im = clamp(ai + bi, c);
            end
            cau_pkg::OP_SUB:
            begin
                r.re = clamp(ar - br, c);
                r.im = clamp(ai - bi, c);
            end
            cau_pkg::OP_MUL:
            begin
                r.re = clamp((ar * br - ai * bi) >>> F, c);
                r.im = clamp((ar * bi + ai * br) >>> F, c);
            end
            cau_pkg::OP_CDIV:
                if (br == 0 && bi == 0) r.st = cau_pkg::ST_DZ;
                else
                begin
                    den = br * br + bi * bi;
                    nr = ar * br + ai * bi;
                    ni = ai * br - ar * bi;
                    r.re = clamp(quot(nr <<< F, den), c);
                    r.im = clamp(quot(ni <<< F, den), c);
                end
            cau_pkg::OP_SCALE:
            begin
                r.re = clamp((ar * br) >>> F, c);
                r.im = clamp((ai * br) >>> F, c);
            end
            cau_pkg::OP_RDIV:
                if (br == 0) r.st = cau_pkg::ST_DZ;
                else
                begin
                    r.re = clamp(quot(ar <<< F, br), c);
                    r.im = clamp(quot(ai <<< F, br), c);
                end
            cau_pkg::OP_CONJ:
            begin
                r.re = it.ar;
                r.im = clamp(-ai, c);
            end
            cau_pkg::OP_MODULUS:
            begin
                mag2 = (2*W+2)'(ar * ar + ai * ai);
                m = root(mag2);
                r.re = clamp($signed({{(W+F+2){1'b0}}, m}), c);
            end
            cau_pkg::OP_EQUAL:
            begin
                nr = ar - br;
                ni = ai - bi;
                if (nr < 0) nr = -nr;
                if (ni < 0) ni = -ni;
                r.eq = (nr < tolerance) && (ni < tolerance);
            end
            default: ;
        endcase
        if (r.st != cau_pkg::ST_DZ && c) r.st = cau_pkg::ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // driver: one beat per pending item with a random gap, back to back when the gap is zero
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(compute_result(pending_ops.pop_front()));
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            end
            else if (!s_tvalid && send_gap > 0)
                send_gap--;
            if (!s_tvalid || s_tready)
            begin
                if (send_gap == 0 && pending_ops.size() > 0)
                begin
                    s_tvalid <= 1;
                    s_tuser <= pending_ops[0].opcode;
                    s_tdata <= {pending_ops[0].bi, pending_ops[0].br,
                                pending_ops[0].ai, pending_ops[0].ar};
                end
                else
                    s_tvalid <= 0;
            end
        end
    end

    // monitor: random stalls on the result side, compare against oldest prediction
    int stall = 0;
    always @(posedge clk)
    begin
        cplx_result_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result beat");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (m_tdata[W-1:0] !== e.re) report_mismatch("res_real", m_tdata[W-1:0], e.re);
                    if (m_tdata[2*W-1:W] !== e.im)
                        report_mismatch("res_imag", m_tdata[2*W-1:W], e.im);
                    if (m_tuser[0] !== e.eq) report_mismatch("are_equal", m_tuser[0], e.eq);
                    if (m_tuser[2:1] !== e.st) report_mismatch("status", m_tuser[2:1], e.st);
                end
                stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            end
            else if (stall > 0)
                stall--;
            // long hold-off, counted here
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_left = HOLD_CYCLES;
            end
            else if (hold_left > 0)
                hold_left--;
            m_tready <= hold_left == 0 && stall == 0;
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return W'($signed($urandom_range(0, 2**20)) - 2**19);
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input logic [3:0] op, input logic [W-1:0] ar, ai, br, bi);
        op_item_t it;
        it.opcode = op; it.ar = ar; it.ai = ai; it.br = br; it.bi = bi;
        pending_ops.push_back(it);
    endtask

    task automatic drain();
        wait (pending_ops.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (LAT + 5) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [cau_pkg::TOL_BITS-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        tolerance = v;
    endtask

    task automatic random_batch(input int n);
        logic [3:0] op;
        for (int i = 0; i < n; i++)
        begin
            op = $urandom_range(0, 20) == 0 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
            add_op(op, rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    logic [W-1:0] x;
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        // directed: extremes, every operation, divide by zero, saturation, unused codes
        add_op(cau_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
        add_op(cau_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
        add_op(cau_pkg::OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        add_op(cau_pkg::OP_MUL, 32'h00018000, 32'hffff0000, 32'h00020000, 32'h00010000);
        add_op(cau_pkg::OP_CDIV, 32'h00010000, 32'h00020000, 0, 0);
        add_op(cau_pkg::OP_CDIV, 32'h00010000, 32'h00020000, 0, 32'h00010000);
        add_op(cau_pkg::OP_CDIV, 32'h7fffffff, 32'h80000000, 1, 1);
        add_op(cau_pkg::OP_SCALE, 32'h00030000, 32'hfffd0000, 32'h80000000, 32'h12345678);
        add_op(cau_pkg::OP_RDIV, 32'h00010000, 32'h00010000, 0, 32'h00010000);
        add_op(cau_pkg::OP_RDIV, 32'h80000000, 32'h00010000, 32'hffffffff, 0);
        add_op(cau_pkg::OP_CONJ, 32'h80000000, 32'h80000000, 0, 0);
        add_op(cau_pkg::OP_CONJ, 32'h12345678, 32'h7fffffff, 0, 0);
        add_op(cau_pkg::OP_MODULUS, 32'h80000000, 32'h80000000, 0, 0);
        add_op(cau_pkg::OP_MODULUS, 32'h00030000, 32'h00040000, 0, 0);
        add_op(cau_pkg::OP_EQUAL, 5, 5, 5, 5);
        add_op(cau_pkg::OP_EQUAL, 5, 5, 6, 5);
        add_op(cau_pkg::OP_EQUAL, 32'h7fffffff, 0, 32'h80000000, 0);
        add_op(4'd9, 1, 2, 3, 4);
        add_op(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        drain();
        // long receiver hold-off so the pipeline fills and stalls the input
        hold_req = 1;
        random_batch(80);
        drain();
        // tolerance settings, extremes included
        foreach (tol_list[k])
        begin
            set_tolerance(tol_list[k]);
            for (int i = 0; i < 10; i++)
            begin
                x = $urandom;
                add_op(cau_pkg::OP_EQUAL, x, x + W'($urandom_range(0, 8)),
                       x - W'($urandom_range(0, 8)), x ^ W'($urandom_range(0, 1)));
            end
            random_batch(55);
            drain();
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_prep.sv
rtl/cau_div_step.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
tb/tb_complex_arithmetic_unit.sv
